// ----- rtl/core/eti_pkg.sv -----
// Shared types and constants for the eased time interpolator.
// Used by the channel interfaces, the fraction divider and the top level.
package eti_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned FRAC_BITS  = 16;
  // quotient bits resolved per divider stage
  localparam int unsigned DIV_STEPS  = 2;
  localparam int unsigned DIV_STAGES = FRAC_BITS / DIV_STEPS;

  localparam logic [FRAC_BITS:0] FIX_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  typedef enum logic [1:0] {
    MODE_LINEAR   = 2'd0,
    MODE_EASE_IN  = 2'd1,
    MODE_EASE_OUT = 2'd2,
    MODE_HOLD     = 2'd3
  } mode_e;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [VALUE_W-1:0]        mag_t;
  typedef logic [TIME_W-1:0]         time_t;
  typedef logic [FRAC_BITS:0]        frac_t;
  typedef logic [FRAC_BITS-1:0]      quo_t;

  // Per-item data that rides along the pipeline next to the fraction.
  typedef struct packed {
    value_t start_value;
    value_t hold_value;   // result when the easing path is skipped
    mag_t   mag;          // |end - start|
    logic   up;           // end > start
    logic   bypass;       // take hold_value
    logic   full;         // now == end, fraction is exactly one
    mode_e  mode;
  } side_t;

endpackage

// ----- rtl/core/eti_if.sv -----
// Valid/ready channel interfaces for the eased time interpolator.
// Depends on eti_pkg for the payload widths.
interface eti_in_if import eti_pkg::*; ();
  logic   valid;
  logic   ready;
  value_t start_value;
  value_t end_value;
  time_t  start_time;
  time_t  end_time;
  time_t  now_time;
  logic [1:0] mode;

  modport source (
    output valid, start_value, end_value, start_time, end_time, now_time, mode,
    input  ready
  );
  modport sink (
    input  valid, start_value, end_value, start_time, end_time, now_time, mode,
    output ready
  );
endinterface

interface eti_out_if import eti_pkg::*; ();
  logic   valid;
  logic   ready;
  value_t value;

  modport source (output valid, value, input ready);
  modport sink (input valid, value, output ready);
endinterface

// ----- rtl/core/eased_time_interpolator.sv -----
// Eased interpolation between two signed 16.16 values over a time window.
// Channels: in_i carries start/end value, start/end/now time and easing mode;
//   out_o carries the interpolated value. Both are valid/ready; a transfer
//   happens on a clock edge with valid and ready high.
// Modes: linear, cubic ease-in, cubic ease-out, hold start. Outside the
//   window, or for an empty window, the end value is returned when now is
//   past start, else the start value; equal values return the start value.
// Pipeline: 14 register stages (input register, 8 divider stages at 2
//   quotient bits each, fraction select, two squaring/cubing multiplies,
//   scale multiply, output add).
// Throughput: one item per cycle while out_o is not stalled; every stage is
//   pipelined and the fraction divider resolves 2 quotient bits per stage.
// Stalls: each stage takes new data when it is empty or the stage after it
//   moves, so bubbles close up while out_o is stalled; in_i.ready drops only
//   when all 14 stages hold an item.
// Reset: rst_ni clears all valid bits; the pipeline comes up empty.
// Depends on eti_pkg, eti_in_if/eti_out_if and eti_div.
module eased_time_interpolator import eti_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  eti_in_if.sink    in_i,
  eti_out_if.source out_o
);

  function automatic frac_t mul_fix(frac_t a, frac_t b);
    logic [2*FRAC_BITS+1:0] p;
    p = a * b;
    return p[2*FRAC_BITS:FRAC_BITS];
  endfunction

  // ---------------- front stage: window checks, span and offset
  value_t v1, v2;
  time_t  t1, t2, tn;
  logic   outside;
  side_t  a_side_d;

  logic   a_v_q;
  time_t  a_num_q, a_den_q;
  side_t  a_side_q;
  logic   a_rdy;
  logic   div_ready;

  assign v1 = in_i.start_value;
  assign v2 = in_i.end_value;
  assign t1 = in_i.start_time;
  assign t2 = in_i.end_time;
  assign tn = in_i.now_time;

  always_comb begin
    outside              = (t2 < tn) || (tn < t1) || (t2 <= t1);
    a_side_d.start_value = v1;
    a_side_d.up          = v2 > v1;
    a_side_d.mag         = a_side_d.up ? mag_t'(v2 - v1) : mag_t'(v1 - v2);
    a_side_d.hold_value  = (outside && (t1 < tn)) ? v2 : v1;
    a_side_d.mode        = mode_e'(in_i.mode);
    a_side_d.bypass      = (v1 == v2) || outside || (a_side_d.mode == MODE_HOLD);
    a_side_d.full        = (tn == t2);
  end

  assign a_rdy      = !a_v_q || div_ready;
  assign in_i.ready = a_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (a_rdy) begin
      a_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_rdy && in_i.valid) begin
      a_num_q  <= tn - t1;
      a_den_q  <= t2 - t1;
      a_side_q <= a_side_d;
    end
  end

  // ---------------- fraction divider
  logic  div_valid;
  quo_t  div_quo;
  side_t div_side;
  logic [5:0] trdy;
  logic [4:0] tv_q;

  eti_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (a_v_q),
    .ready_o (div_ready),
    .num_i   (a_num_q),
    .den_i   (a_den_q),
    .side_i  (a_side_q),
    .valid_o (div_valid),
    .ready_i (trdy[0]),
    .quo_o   (div_quo),
    .side_o  (div_side)
  );

  // tail stages: 0 fraction select, 1 square, 2 cube, 3 scale, 4 output
  assign trdy[5] = out_o.ready;
  for (genvar i = 0; i < 5; i++) begin : g_rdy
    assign trdy[i] = !tv_q[i] || trdy[i+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tv_q <= '0;
    end else begin
      if (trdy[0]) tv_q[0] <= div_valid;
      if (trdy[1]) tv_q[1] <= tv_q[0];
      if (trdy[2]) tv_q[2] <= tv_q[1];
      if (trdy[3]) tv_q[3] <= tv_q[2];
      if (trdy[4]) tv_q[4] <= tv_q[3];
    end
  end

  // ---------------- fraction select; ease-out works on 1 - f
  frac_t b_f_d, b_x_d;
  frac_t b_f_q, b_x_q;
  side_t b_side_q;

  always_comb begin
    b_f_d = div_side.full ? FIX_ONE : {1'b0, div_quo};
    b_x_d = (div_side.mode == MODE_EASE_OUT) ? frac_t'(FIX_ONE - b_f_d) : b_f_d;
  end

  always_ff @(posedge clk_i) begin
    if (trdy[0] && div_valid) begin
      b_f_q    <= b_f_d;
      b_x_q    <= b_x_d;
      b_side_q <= div_side;
    end
  end

  // ---------------- square
  frac_t c_f_q, c_x_q, c_x2_q;
  side_t c_side_q;

  always_ff @(posedge clk_i) begin
    if (trdy[1] && tv_q[0]) begin
      c_f_q    <= b_f_q;
      c_x_q    <= b_x_q;
      c_x2_q   <= mul_fix(b_x_q, b_x_q);
      c_side_q <= b_side_q;
    end
  end

  // ---------------- cube
  frac_t d_f_q, d_cube_q;
  side_t d_side_q;

  always_ff @(posedge clk_i) begin
    if (trdy[2] && tv_q[1]) begin
      d_f_q    <= c_f_q;
      d_cube_q <= mul_fix(c_x2_q, c_x_q);
      d_side_q <= c_side_q;
    end
  end

  // ---------------- easing select and scale of |end - start|
  frac_t                    e_sel;
  logic [VALUE_W+FRAC_BITS:0] e_prod;
  mag_t                     e_scaled_q;
  side_t                    e_side_q;

  always_comb begin
    case (d_side_q.mode)
      MODE_LINEAR:   e_sel = d_f_q;
      MODE_EASE_IN:  e_sel = d_cube_q;
      MODE_EASE_OUT: e_sel = frac_t'(FIX_ONE - d_cube_q);
      default:       e_sel = '0;
    endcase
    e_prod = d_side_q.mag * e_sel;
  end

  always_ff @(posedge clk_i) begin
    if (trdy[3] && tv_q[2]) begin
      e_scaled_q <= e_prod[VALUE_W+FRAC_BITS-1:FRAC_BITS];
      e_side_q   <= d_side_q;
    end
  end

  // ---------------- output register
  value_t f_value_d, f_value_q;

  always_comb begin
    if (e_side_q.bypass) begin
      f_value_d = e_side_q.hold_value;
    end else if (e_side_q.up) begin
      f_value_d = e_side_q.start_value + value_t'(e_scaled_q);
    end else begin
      f_value_d = e_side_q.start_value - value_t'(e_scaled_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (trdy[4] && tv_q[3]) begin
      f_value_q <= f_value_d;
    end
  end

  assign out_o.valid = tv_q[4];
  assign out_o.value = f_value_q;

`ifndef ASSERT_OFF
  // input back-pressure only when the whole pipe is full behind a stalled output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (out_o.valid && !out_o.ready))
    else $error("input stalled while output is not stalled");

  // fraction never exceeds one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tv_q[0] |-> (b_f_q <= FIX_ONE && b_x_q <= FIX_ONE))
    else $error("fraction above one");

  // scaled step never exceeds the distance between the values
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tv_q[3] |-> (e_scaled_q <= e_side_q.mag))
    else $error("scaled increment exceeds magnitude");
`endif

endmodule

// ----- rtl/core/eti_div.sv -----
// Pipelined restoring divider: floor(num * 2^FRAC_BITS / den) for num < den.
// Depends on eti_pkg; carries a side_t record alongside each quotient.
module eti_div import eti_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  time_t num_i,
  input  time_t den_i,
  input  side_t side_i,
  output logic  valid_o,
  input  logic  ready_i,
  output quo_t  quo_o,
  output side_t side_o
);

  logic [DIV_STAGES-1:0] valid_q;
  logic [DIV_STAGES:0]   rdy;
  time_t rem_q  [DIV_STAGES];
  time_t den_q  [DIV_STAGES];
  quo_t  quo_q  [DIV_STAGES];
  side_t side_q [DIV_STAGES];

  assign rdy[DIV_STAGES] = ready_i;

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic          v_in;
    time_t         rem_in;
    time_t         den_in;
    quo_t          quo_in;
    side_t         side_in;
    time_t         rem_d;
    quo_t          quo_d;
    logic [TIME_W:0] sh;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = num_i;
      assign den_in  = den_i;
      assign quo_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = valid_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign den_in  = den_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign side_in = side_q[k-1];
    end

    always_comb begin
      rem_d = rem_in;
      quo_d = quo_in;
      sh    = '0;
      for (int s = 0; s < DIV_STEPS; s++) begin
        sh    = {rem_d, 1'b0};
        quo_d = {quo_d[FRAC_BITS-2:0], 1'b0};
        if (sh >= {1'b0, den_in}) begin
          sh       = sh - {1'b0, den_in};
          quo_d[0] = 1'b1;
        end
        rem_d = sh[TIME_W-1:0];
      end
    end

    assign rdy[k] = !valid_q[k] || rdy[k+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && v_in) begin
        rem_q[k]  <= rem_d;
        den_q[k]  <= den_in;
        quo_q[k]  <= quo_d;
        side_q[k] <= side_in;
      end
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = valid_q[DIV_STAGES-1];
  assign quo_o   = quo_q[DIV_STAGES-1];
  assign side_o  = side_q[DIV_STAGES-1];

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for eased_time_interpolator: directed corner items,
// random windows, a long output hold-off and random noise.
// Depends on eti_pkg and the eti_in_if/eti_out_if channel interfaces.
`timescale 1ns / 100ps

module testbench;
  import eti_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 40;

  typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_style_e;

  typedef struct {
    value_t start_value;
    value_t end_value;
    time_t  start_time;
    time_t  end_time;
    time_t  now_time;
    mode_e  mode;
  } interp_item_t;

  logic clk;
  logic rst_ni;

  eti_in_if  in_ch ();
  eti_out_if out_ch ();

  eased_time_interpolator uut (
    .clk_i  (clk),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  value_t      pending_values[$];
  int unsigned error_count  = 0;
  int unsigned burst_left   = 0;
  int unsigned tx_gap_max   = 0;
  int unsigned hold_request = 0;
  rx_style_e   rx_style     = RX_ALWAYS;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Expected value
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] fixed_cube(input logic [63:0] x);
    logic [63:0] sq;
    sq = (x * x) >> FRAC_BITS;
    return (sq * x) >> FRAC_BITS;
  endfunction

  function automatic value_t eased_value(input interp_item_t it);
    logic [63:0] one, span, elapsed, frac, ease, mag, step;
    logic signed [63:0] s64, e64;
    logic up;
    one = 64'd1 << FRAC_BITS;
    if (it.start_value == it.end_value) return it.start_value;
    if (it.now_time > it.end_time || it.now_time < it.start_time ||
        it.end_time <= it.start_time) begin
      return (it.now_time > it.start_time) ? it.end_value : it.start_value;
    end
    if (it.mode == MODE_HOLD) return it.start_value;
    span    = 64'(it.end_time) - 64'(it.start_time);
    elapsed = 64'(it.now_time) - 64'(it.start_time);
    frac    = (elapsed == span) ? one : (elapsed << FRAC_BITS) / span;
    case (it.mode)
      MODE_LINEAR:  ease = frac;
      MODE_EASE_IN: ease = fixed_cube(frac);
      default:      ease = one - fixed_cube(one - frac);
    endcase
    s64  = it.start_value;
    e64  = it.end_value;
    up   = e64 > s64;
    mag  = up ? 64'(e64 - s64) : 64'(s64 - e64);
    // truncation toward zero keeps the result between the two values
    step = (mag * ease) >> FRAC_BITS;
    return up ? value_t'(s64 + $signed(step)) : value_t'(s64 - $signed(step));
  endfunction

  // ---------------------------------------------------------------------------
  // Item generation
  // ---------------------------------------------------------------------------
  function automatic interp_item_t make_item(input value_t sv, input value_t ev,
                                             input time_t t1, input time_t t2,
                                             input time_t tn, input mode_e md);
    interp_item_t it;
    it.start_value = sv;
    it.end_value   = ev;
    it.start_time  = t1;
    it.end_time    = t2;
    it.now_time    = tn;
    it.mode        = md;
    return it;
  endfunction

  function automatic value_t random_value();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return '0;
      3:       return value_t'($urandom_range(0, 32'h0003_0000));
      default: return value_t'($urandom);
    endcase
  endfunction

  // mostly inside the window, with now on the edges now and then
  function automatic interp_item_t window_item();
    interp_item_t it;
    time_t span;
    it.start_value = random_value();
    case ($urandom_range(0, 9))
      0:       it.end_value = it.start_value;
      1, 2:    it.end_value = it.start_value ^ value_t'($urandom_range(1, 255));
      default: it.end_value = random_value();
    endcase
    case ($urandom_range(0, 3))
      0:       span = $urandom_range(1, 8);
      1:       span = $urandom_range(9, 4096);
      default: span = $urandom_range(1, 32'hFFFF_FFFF);
    endcase
    it.start_time = $urandom_range(0, 32'hFFFF_FFFF - span);
    it.end_time   = it.start_time + span;
    case ($urandom_range(0, 9))
      0:       it.now_time = it.start_time;
      1:       it.now_time = it.end_time;
      default: it.now_time = it.start_time + $urandom_range(0, span);
    endcase
    it.mode = mode_e'($urandom_range(0, 3));
    return it;
  endfunction

  function automatic interp_item_t noise_item();
    interp_item_t it;
    it.start_value = random_value();
    it.end_value   = random_value();
    it.start_time  = $urandom;
    it.end_time    = $urandom;
    it.now_time    = $urandom;
    it.mode        = mode_e'($urandom_range(0, 3));
    case ($urandom_range(0, 5))
      0: it.now_time = it.start_time;
      1: it.now_time = it.end_time;
      2: it.end_time = it.start_time;
      default: ;
    endcase
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  task automatic send_item(input interp_item_t it);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      if (tx_gap_max != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, tx_gap_max)) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid       <= 1'b1;
    in_ch.start_value <= it.start_value;
    in_ch.end_value   <= it.end_value;
    in_ch.start_time  <= it.start_time;
    in_ch.end_time    <= it.end_time;
    in_ch.now_time    <= it.now_time;
    in_ch.mode        <= it.mode;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pending_values.push_back(eased_value(it));
  endtask

  // sender goes quiet until every queued result is back
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_values.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int unsigned hold_left;
    logic [7:0] rx_pattern;
    out_ch.ready = 1'b0;
    rx_pattern = 8'b1101_0110;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
        out_ch.ready <= 1'b0;
        while (hold_left != 0) begin
          @(posedge clk);
          hold_left--;
        end
      end else begin
        rx_pattern = {rx_pattern[6:0], rx_pattern[7]};
        case (rx_style)
          RX_ALWAYS: out_ch.ready <= 1'b1;
          RX_RANDOM: out_ch.ready <= ($urandom_range(0, 99) < 65);
          default:   out_ch.ready <= rx_pattern[0];
        endcase
      end
    end
  end

  initial begin : result_checker
    value_t want;
    forever begin
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (pending_values.size() == 0) begin
          $error("unexpected result: value %0d", out_ch.value);
          error_count++;
        end else begin
          want = pending_values.pop_front();
          if (out_ch.value !== want) begin
            $error("value mismatch: expected %0d actual %0d", want, out_ch.value);
            error_count++;
          end
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    rx_style   = RX_RANDOM;
    tx_gap_max = 3;
    // equal values
    send_item(make_item(32'h0001_8000, 32'h0001_8000, 100, 200, 150, MODE_LINEAR));
    // past the end, before the start
    send_item(make_item(32'h0001_0000, 32'h0005_0000, 100, 200, 300, MODE_LINEAR));
    send_item(make_item(32'h0001_0000, 32'h0005_0000, 100, 200, 50, MODE_EASE_IN));
    // empty and inverted windows
    send_item(make_item(32'h0001_0000, 32'h0005_0000, 100, 100, 101, MODE_LINEAR));
    send_item(make_item(32'h0001_0000, 32'h0005_0000, 100, 100, 100, MODE_EASE_OUT));
    send_item(make_item(32'h0001_0000, 32'h0005_0000, 200, 100, 200, MODE_LINEAR));
    send_item(make_item(32'h0001_0000, 32'h0005_0000, 200, 100, 150, MODE_EASE_IN));
    send_item(make_item(32'h0001_0000, 32'h0005_0000, 200, 100, 250, MODE_HOLD));
    send_item(make_item(32'h0001_0000, 32'h0005_0000, '1, '1, '1, MODE_LINEAR));
    send_item(make_item(32'h0001_0000, 32'h0005_0000, 0, 0, 0, MODE_LINEAR));
    // hold inside the window and at its end
    send_item(make_item(32'h0001_0000, 32'h0005_0000, 100, 200, 150, MODE_HOLD));
    send_item(make_item(32'h0001_0000, 32'h0005_0000, 100, 200, 200, MODE_HOLD));
    // fraction of exactly one, full value range
    send_item(make_item(32'h8000_0000, 32'h7FFF_FFFF, 0, '1, '1, MODE_LINEAR));
    send_item(make_item(32'h8000_0000, 32'h7FFF_FFFF, 0, '1, '1, MODE_EASE_IN));
    send_item(make_item(32'h8000_0000, 32'h7FFF_FFFF, 0, '1, '1, MODE_EASE_OUT));
    // zero fraction
    send_item(make_item(32'h7FFF_FFFF, 32'h8000_0000, 10, 20, 10, MODE_LINEAR));
    send_item(make_item(32'h7FFF_FFFF, 32'h8000_0000, 10, 20, 10, MODE_EASE_IN));
    send_item(make_item(32'h7FFF_FFFF, 32'h8000_0000, 10, 20, 10, MODE_EASE_OUT));
    // mid window, falling, widest span
    send_item(make_item(32'h7FFF_FFFF, 32'h8000_0000, 0, '1, 32'h7FFF_FFFF, MODE_LINEAR));
    send_item(make_item(32'h7FFF_FFFF, 32'h8000_0000, 0, '1, 32'h7FFF_FFFF, MODE_EASE_IN));
    send_item(make_item(32'h7FFF_FFFF, 32'h8000_0000, 0, '1, 32'h7FFF_FFFF, MODE_EASE_OUT));
    // span of one tick at the top of the time range
    send_item(make_item(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFE, '1, 32'hFFFF_FFFE,
                        MODE_LINEAR));
    send_item(make_item(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFE, '1, '1, MODE_EASE_OUT));
    // small step, truncation toward zero on both sides
    send_item(make_item(32'hFFFF_FFFF, 32'h0000_0001, 0, 3, 1, MODE_LINEAR));
    send_item(make_item(32'h0000_0001, 32'hFFFF_FFFF, 0, 3, 1, MODE_EASE_OUT));
    wait_for_results();
  endtask

  task automatic test_random_windows();
    for (int chunk = 0; chunk < 5; chunk++) begin
      rx_style   = rx_style_e'(chunk % 3);
      tx_gap_max = (chunk == 0) ? 0 : $urandom_range(2, 12);
      for (int i = 0; i < 130; i++) begin
        if ($urandom_range(0, 99) < 85) send_item(window_item());
        else send_item(noise_item());
      end
    end
    wait_for_results();
  endtask

  // output held off long enough for the pipeline to fill and stall in_ch
  task automatic test_backpressure();
    rx_style     = RX_ALWAYS;
    tx_gap_max   = 0;
    hold_request = 150;
    for (int i = 0; i < 80; i++) send_item(window_item());
    wait_for_results();
    rx_style     = RX_PATTERN;
    hold_request = 60;
    for (int i = 0; i < 40; i++) send_item(window_item());
    wait_for_results();
  endtask

  task automatic test_noise();
    rx_style   = RX_RANDOM;
    tx_gap_max = 4;
    for (int i = 0; i < 260; i++) send_item(noise_item());
    wait_for_results();
  endtask

  initial begin
    rst_ni            = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.start_value = '0;
    in_ch.end_value   = '0;
    in_ch.start_time  = '0;
    in_ch.end_time    = '0;
    in_ch.now_time    = '0;
    in_ch.mode        = MODE_LINEAR;
    repeat (8) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_windows();
    test_backpressure();
    test_noise();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- eased_time_interpolator.f -----
rtl/core/eti_pkg.sv
rtl/core/eti_if.sv
rtl/core/eti_div.sv
rtl/core/eased_time_interpolator.sv
tb/testbench.sv
